[rtl/core/tcpq_pkg.sv]
// Shared types and constants for the two-class priority queue.
package tcpq_pkg;

  // Fixed widths of the packet fields.
  localparam int ID_W     = 16;
  localparam int DEST_W   = 8;
  localparam int WEIGHT_W = 16;
  localparam int ENTRY_W  = ID_W + DEST_W + WEIGHT_W;

  // Heavy threshold after reset: a weight of 20 in units of one sixteenth.
  localparam logic [WEIGHT_W-1:0] THRESH_RESET = 16'd320;

  // Request codes carried on the mode field.
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  typedef logic [1:0] status_t;

  // Result status codes.
  localparam status_t ST_ENQ   = 2'd0;
  localparam status_t ST_DEQ   = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  // One stored packet.
  typedef struct packed {
    logic [ID_W-1:0]     id;
    logic [DEST_W-1:0]   dest;
    logic [WEIGHT_W-1:0] wt;
  } entry_t;

  // Occupancy flags of one class FIFO.
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

[rtl/core/tcpq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module tcpq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/tcpq_fifo_ctrl.sv]
// Read pointer, write pointer and fill count of one class FIFO.
module tcpq_fifo_ctrl #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic                       pop,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [$clog2(DEPTH)-1:0]   rd_addr,
  output tcpq_pkg::fifo_stat_t       stat
);
  import tcpq_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Push and pop never arrive in the same cycle; the caller gates them
  // against full and empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
        count  <= count + CNT_W'(1);
      end else if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
        count  <= count - CNT_W'(1);
      end
    end
  end

  assign wr_addr    = wr_ptr;
  assign rd_addr    = rd_ptr;
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CNT_FULL);

endmodule

[rtl/core/two_class_priority_queue.sv]
// Top level of the two-class strict priority packet queue.
//
// Usage: each input transaction on the in channel is one request. With mode
// at enqueue, the packet (packet_id, destination, weight) joins the heavy
// class when its weight is strictly above heavy_threshold and the light class
// otherwise; a class that already holds CLASS_DEPTH packets drops it and the
// result reports full. With mode at dequeue, the oldest heavy packet leaves,
// or if there is none the oldest light one; with both classes empty the
// result reports empty. Every request gives exactly one result transaction
// on the out channel, and the packet fields of a result are zero unless the
// status is dequeued.
// The result of a request is registered and offered in the cycle after the
// request is accepted. Throughput is one request per cycle while the receiver
// takes results, set by the one write or one read that a request makes on a
// class memory. The cfg channel writes heavy_threshold and is always ready;
// the user must write it only while the queue is idle (not enforced here).
// Reset empties both classes (pointers and counts cleared, memory contents
// left as they are), clears out_valid and sets the threshold to 320.
// When the receiver stalls, the result register holds and in_ready drops, so
// no further request is taken until the pending result is taken.
module two_class_priority_queue #(
  parameter int CLASS_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              mode,
  input  logic [tcpq_pkg::ID_W-1:0]         packet_id,
  input  logic [tcpq_pkg::DEST_W-1:0]       destination,
  input  logic [tcpq_pkg::WEIGHT_W-1:0]     weight,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output tcpq_pkg::status_t                 status,
  output logic [tcpq_pkg::ID_W-1:0]         out_packet_id,
  output logic [tcpq_pkg::DEST_W-1:0]       out_destination,
  output logic [tcpq_pkg::WEIGHT_W-1:0]     out_weight,
  // Configuration channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [tcpq_pkg::WEIGHT_W-1:0]     cfg_data
);
  import tcpq_pkg::*;

  localparam int PTR_W = $clog2(CLASS_DEPTH);

  logic [WEIGHT_W-1:0] heavy_threshold;

  logic             accept;
  logic             is_heavy;
  logic             do_enq;
  logic             do_deq;
  logic             heavy_push;
  logic             light_push;
  logic             heavy_pop;
  logic             light_pop;
  entry_t           in_entry;
  status_t          status_next;

  fifo_stat_t       heavy_stat;
  fifo_stat_t       light_stat;
  logic [PTR_W-1:0] heavy_wr_addr;
  logic [PTR_W-1:0] heavy_rd_addr;
  logic [PTR_W-1:0] light_wr_addr;
  logic [PTR_W-1:0] light_rd_addr;
  entry_t           heavy_rdata;
  entry_t           light_rdata;

  // Result stage: status and which class memory feeds the packet fields.
  status_t          status_reg;
  logic             sel_heavy;
  entry_t           out_entry;

  // Configuration register. Writes are taken in every cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heavy_threshold <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      heavy_threshold <= cfg_data;
    end
  end

  // A request is taken whenever the result register is free or is being
  // emptied in this same cycle.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_heavy = (weight > heavy_threshold);
  assign do_enq   = accept && (mode == MODE_ENQ);
  assign do_deq   = accept && (mode == MODE_DEQ);

  // A full class drops the packet, so the push is simply suppressed.
  assign heavy_push = do_enq && is_heavy && !heavy_stat.full;
  assign light_push = do_enq && !is_heavy && !light_stat.full;

  // Strict priority: the light class is served only when no heavy packet
  // is waiting.
  assign heavy_pop = do_deq && !heavy_stat.empty;
  assign light_pop = do_deq && heavy_stat.empty && !light_stat.empty;

  assign in_entry.id   = packet_id;
  assign in_entry.dest = destination;
  assign in_entry.wt   = weight;

  always_comb begin
    if (mode == MODE_ENQ) begin
      status_next = (is_heavy ? heavy_stat.full : light_stat.full) ? ST_FULL : ST_ENQ;
    end else begin
      status_next = (heavy_stat.empty && light_stat.empty) ? ST_EMPTY : ST_DEQ;
    end
  end

  tcpq_fifo_ctrl #(
    .DEPTH (CLASS_DEPTH)
  ) u_heavy_ctrl (
    .clk     (clk),
    .rst     (rst),
    .push    (heavy_push),
    .pop     (heavy_pop),
    .wr_addr (heavy_wr_addr),
    .rd_addr (heavy_rd_addr),
    .stat    (heavy_stat)
  );

  tcpq_fifo_ctrl #(
    .DEPTH (CLASS_DEPTH)
  ) u_light_ctrl (
    .clk     (clk),
    .rst     (rst),
    .push    (light_push),
    .pop     (light_pop),
    .wr_addr (light_wr_addr),
    .rd_addr (light_rd_addr),
    .stat    (light_stat)
  );

  // The read data registers of the memories are part of the result stage:
  // they load only on a dequeue and hold while the receiver stalls, since no
  // request is taken then.
  tcpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CLASS_DEPTH)
  ) u_heavy_ram (
    .clk   (clk),
    .we    (heavy_push),
    .waddr (heavy_wr_addr),
    .wdata (in_entry),
    .re    (heavy_pop),
    .raddr (heavy_rd_addr),
    .rdata (heavy_rdata)
  );

  tcpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CLASS_DEPTH)
  ) u_light_ram (
    .clk   (clk),
    .we    (light_push),
    .waddr (light_wr_addr),
    .wdata (in_entry),
    .re    (light_pop),
    .raddr (light_rd_addr),
    .rdata (light_rdata)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_reg <= status_next;
      sel_heavy  <= heavy_pop;
    end
  end

  assign out_entry = sel_heavy ? heavy_rdata : light_rdata;

  // Packet fields are forced to zero unless a packet actually left.
  assign status          = status_reg;
  assign out_packet_id   = (status_reg == ST_DEQ) ? out_entry.id   : '0;
  assign out_destination = (status_reg == ST_DEQ) ? out_entry.dest : '0;
  assign out_weight      = (status_reg == ST_DEQ) ? out_entry.wt   : '0;

endmodule
